### rtl/core/mse_pkg.sv
// ----------------------------------------------------------------------------
// mse_pkg
// Shared types and constants for the merge sort engine.
// ----------------------------------------------------------------------------
package mse_pkg;

  localparam int MAX_KEYS = 64;
  localparam int IDX_W    = $clog2(MAX_KEYS);
  localparam int CNT_W    = IDX_W + 1;
  localparam int KEY_W    = 32;
  localparam int ADDR_W   = 3;
  localparam int DATA_W   = 32;

  // register index, taken from paddr[ADDR_W-1:2]
  localparam logic [ADDR_W-3:0] REG_SORT_DESC = 1'b0;

  typedef struct packed {
    logic signed [KEY_W-1:0] key_value;
    logic                    is_last;
  } key_item_t;

  typedef struct packed {
    logic signed [KEY_W-1:0] sorted_key;
    logic                    last_of_run;
    logic                    overflowed;
  } result_item_t;

  typedef struct packed {
    logic store;      // key transaction: write key or flag overflow
    logic sort_init;  // set up first merge pass
    logic merge;      // one merge step
    logic emit_init;  // single key batch: emit straight from key store
    logic emit_load;  // load next sorted key into the output register
    logic done;       // batch delivered, clear count and overflow
  } mse_cmd_t;

  typedef struct packed {
    logic             single_key;
    logic             pass_end;
    logic             sort_done;
    logic             emit_last;
    logic             out_free;
    logic [CNT_W-1:0] key_count;
  } mse_sts_t;

endpackage

### rtl/core/merge_sort_engine.sv
// Sequence: after the closing key, a set-up state, then ceil(log2 n) merge passes
//   with a bubble state between passes, then the output register loads the first key.
// Throughput: sorted keys leave at one per cycle while result_ready stays high;
//   the merge does a single compare/write step per cycle.
// Reset: key count and overflow cleared, sort_descending set to 1; key store
//   and merge buffer are not cleared.
// ----------------------------------------------------------------------------
// merge_sort_engine
// Batch merge sorter for signed 32-bit keys, bottom-up with ping-pong buffers.
// ----------------------------------------------------------------------------
module merge_sort_engine (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          key_valid,
  output logic                          key_ready,
  input  mse_pkg::key_item_t            key_data,
  output logic                          result_valid,
  input  logic                          result_ready,
  output mse_pkg::result_item_t         result_data,
  input  logic                          psel,
  input  logic                          penable,
  input  logic                          pwrite,
  input  logic [mse_pkg::ADDR_W-1:0]    paddr,
  input  logic [mse_pkg::DATA_W-1:0]    pwdata,
  output logic [mse_pkg::DATA_W-1:0]    prdata,
  output logic                          pready
);

  mse_pkg::mse_cmd_t cmd;
  mse_pkg::mse_sts_t sts;
  logic              sort_descending;
  logic              reg_hit;

  assign pready  = 1'b1;
  assign reg_hit = (paddr[mse_pkg::ADDR_W-1:2] == mse_pkg::REG_SORT_DESC);

  always_ff @(posedge clk) begin
    if (rst) begin
      sort_descending <= 1'b1;
    end else if (psel && penable && pwrite && reg_hit) begin
      sort_descending <= pwdata[0];
    end
  end

  assign prdata = reg_hit ? {{(mse_pkg::DATA_W-1){1'b0}}, sort_descending} : '0;

  mse_controller u_ctrl (
    .clk         (clk),
    .rst         (rst),
    .key_valid   (key_valid),
    .key_is_last (key_data.is_last),
    .sts         (sts),
    .key_ready   (key_ready),
    .cmd         (cmd)
  );

  mse_datapath u_dp (
    .clk             (clk),
    .rst             (rst),
    .cmd             (cmd),
    .sts             (sts),
    .key_data        (key_data),
    .sort_descending (sort_descending),
    .result_ready    (result_ready),
    .result_valid    (result_valid),
    .result_data     (result_data)
  );

  a_count_bound: assert property (@(posedge clk) disable iff (rst)
    sts.key_count <= mse_pkg::CNT_W'(mse_pkg::MAX_KEYS))
    else $error("key count beyond capacity");

  a_emit_nonempty: assert property (@(posedge clk) disable iff (rst)
    cmd.emit_load |-> (sts.key_count != '0))
    else $error("emitting from an empty batch");

  a_no_merge_emit: assert property (@(posedge clk) disable iff (rst)
    (cmd.merge && sts.sort_done) |=> !cmd.merge && !key_ready)
    else $error("merge carried on past the final pass");

  a_reset_idle: assert property (@(posedge clk)
    $past(rst) |-> key_ready && !result_valid)
    else $error("not idle after reset");

endmodule

### rtl/core/mse_controller.sv
// ----------------------------------------------------------------------------
// mse_controller
// Sequencer: collect keys, run the merge passes, emit the sorted batch.
// ----------------------------------------------------------------------------
module mse_controller (
  input  logic              clk,
  input  logic              rst,
  input  logic              key_valid,
  input  logic              key_is_last,
  input  mse_pkg::mse_sts_t sts,
  output logic              key_ready,
  output mse_pkg::mse_cmd_t cmd
);

  localparam logic [2:0] ST_COLLECT = 3'd0;
  localparam logic [2:0] ST_START   = 3'd1;
  localparam logic [2:0] ST_MERGE   = 3'd2;
  localparam logic [2:0] ST_PRIME   = 3'd3;
  localparam logic [2:0] ST_EMIT    = 3'd4;

  logic [2:0] state;
  logic [2:0] state_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_COLLECT;
    end else begin
      state <= state_next;
    end
  end

  assign key_ready = (state == ST_COLLECT);

  always_comb begin
    state_next = state;
    cmd        = '0;
    unique case (state)
      ST_COLLECT: begin
        if (key_valid) begin
          cmd.store = 1'b1;
          if (key_is_last) state_next = ST_START;
        end
      end
      ST_START: begin
        if (sts.single_key) begin
          cmd.emit_init = 1'b1;
          state_next    = ST_EMIT;
        end else begin
          cmd.sort_init = 1'b1;
          state_next    = ST_MERGE;
        end
      end
      ST_MERGE: begin
        cmd.merge = 1'b1;
        if (sts.pass_end) state_next = sts.sort_done ? ST_EMIT : ST_PRIME;
      end
      // one bubble so the last write of a pass lands before it is read back
      ST_PRIME: begin
        state_next = ST_MERGE;
      end
      ST_EMIT: begin
        if (sts.out_free) begin
          cmd.emit_load = 1'b1;
          if (sts.emit_last) begin
            cmd.done   = 1'b1;
            state_next = ST_COLLECT;
          end
        end
      end
      default: state_next = ST_COLLECT;
    endcase
  end

endmodule

### rtl/core/mse_datapath.sv
// ----------------------------------------------------------------------------
// mse_datapath
// Key store and merge buffer used as a ping-pong pair, merge compare/select,
// run bookkeeping and the output register.
// ----------------------------------------------------------------------------
module mse_datapath (
  input  logic                    clk,
  input  logic                    rst,
  input  mse_pkg::mse_cmd_t       cmd,
  output mse_pkg::mse_sts_t       sts,
  input  mse_pkg::key_item_t      key_data,
  input  logic                    sort_descending,
  input  logic                    result_ready,
  output logic                    result_valid,
  output mse_pkg::result_item_t   result_data
);

  localparam int CW = mse_pkg::CNT_W;
  localparam int IW = mse_pkg::IDX_W;
  localparam int KW = mse_pkg::KEY_W;

  logic [KW-1:0] key_store    [mse_pkg::MAX_KEYS];
  logic [KW-1:0] merge_buffer [mse_pkg::MAX_KEYS];

  logic [CW-1:0] key_count;
  logic          overflow_seen;

  // run bookkeeping; i also walks the batch during emission
  logic [CW-1:0] i, j, d, mid, hi, w;
  logic [CW-1:0] i_next, j_next, d_next, mid_next, hi_next, w_next;
  logic          sel, sel_next;  // 0: data in key store, 1: in merge buffer

  logic [KW-1:0]        ks_rd_a, ks_rd_b, mb_rd_a, mb_rd_b;
  logic signed [KW-1:0] rd_a, rd_b;

  logic          ks_we, mb_we;
  logic [IW-1:0] ks_waddr, mb_waddr;
  logic [KW-1:0] ks_wdata, mb_wdata;

  logic          a_ok, b_ok, a_first, take_a;
  logic [CW-1:0] d_step, w_dbl, w_quad, last_idx;
  logic          seg_end, pass_end, sort_done, room;
  logic [KW-1:0] merge_word;

  function automatic logic [CW-1:0] seg_bound(input logic [CW-1:0] lo,
                                              input logic [CW-1:0] span,
                                              input logic [CW-1:0] n);
    logic [CW:0] s;
    s = {1'b0, lo} + {1'b0, span};
    return (s < {1'b0, n}) ? s[CW-1:0] : n;
  endfunction

  assign rd_a = sel ? mb_rd_a : ks_rd_a;
  assign rd_b = sel ? mb_rd_b : ks_rd_b;

  assign room     = (key_count < CW'(mse_pkg::MAX_KEYS));
  assign a_ok     = (i < mid);
  assign b_ok     = (j < hi);
  assign a_first  = sort_descending ? (rd_a > rd_b) : (rd_a < rd_b);
  assign take_a   = a_ok && (!b_ok || a_first);
  assign merge_word = take_a ? rd_a : rd_b;
  assign d_step   = d + CW'(1);
  assign w_dbl    = w << 1;
  assign w_quad   = w << 2;
  assign seg_end  = (d_step == hi);
  assign pass_end = seg_end && (hi == key_count);
  assign sort_done = pass_end && (w_dbl >= key_count);
  assign last_idx = key_count - CW'(1);

  always_comb begin
    i_next   = i;
    j_next   = j;
    d_next   = d;
    mid_next = mid;
    hi_next  = hi;
    w_next   = w;
    sel_next = sel;
    ks_we    = 1'b0;
    mb_we    = 1'b0;
    ks_waddr = key_count[IW-1:0];
    ks_wdata = key_data.key_value;
    mb_waddr = d[IW-1:0];
    mb_wdata = merge_word;

    if (cmd.store && room) ks_we = 1'b1;

    if (cmd.sort_init) begin
      w_next   = CW'(1);
      sel_next = 1'b0;
      i_next   = '0;
      d_next   = '0;
      mid_next = seg_bound('0, CW'(1), key_count);
      j_next   = mid_next;
      hi_next  = seg_bound('0, CW'(2), key_count);
    end

    if (cmd.emit_init) begin
      i_next   = '0;
      sel_next = 1'b0;
    end

    if (cmd.merge) begin
      if (sel) begin
        ks_we    = 1'b1;
        ks_waddr = d[IW-1:0];
        ks_wdata = merge_word;
      end else begin
        mb_we    = 1'b1;
      end
      if (!seg_end) begin
        i_next = take_a ? i + CW'(1) : i;
        j_next = take_a ? j : j + CW'(1);
        d_next = d_step;
      end else if (!pass_end) begin
        // next pair of runs starts where this one ended
        i_next   = hi;
        d_next   = hi;
        mid_next = seg_bound(hi, w, key_count);
        j_next   = mid_next;
        hi_next  = seg_bound(hi, w_dbl, key_count);
      end else if (!sort_done) begin
        w_next   = w_dbl;
        sel_next = !sel;
        i_next   = '0;
        d_next   = '0;
        mid_next = seg_bound('0, w_dbl, key_count);
        j_next   = mid_next;
        hi_next  = seg_bound('0, w_quad, key_count);
      end else begin
        sel_next = !sel;
        i_next   = '0;
      end
    end

    if (cmd.emit_load) i_next = i + CW'(1);
  end

  always_ff @(posedge clk) begin
    i   <= i_next;
    j   <= j_next;
    d   <= d_next;
    mid <= mid_next;
    hi  <= hi_next;
    w   <= w_next;
    sel <= sel_next;
  end

  always_ff @(posedge clk) begin
    if (ks_we) key_store[ks_waddr] <= ks_wdata;
    ks_rd_a <= key_store[i_next[IW-1:0]];
    ks_rd_b <= key_store[j_next[IW-1:0]];
  end

  always_ff @(posedge clk) begin
    if (mb_we) merge_buffer[mb_waddr] <= mb_wdata;
    mb_rd_a <= merge_buffer[i_next[IW-1:0]];
    mb_rd_b <= merge_buffer[j_next[IW-1:0]];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      key_count     <= '0;
      overflow_seen <= 1'b0;
    end else if (cmd.done) begin
      key_count     <= '0;
      overflow_seen <= 1'b0;
    end else if (cmd.store) begin
      if (room) key_count <= key_count + CW'(1);
      else      overflow_seen <= 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      result_valid <= 1'b0;
    end else if (cmd.emit_load) begin
      result_valid <= 1'b1;
    end else if (result_ready) begin
      result_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.emit_load) begin
      result_data.sorted_key  <= rd_a;
      result_data.last_of_run <= (i == last_idx);
      result_data.overflowed  <= overflow_seen;
    end
  end

  assign sts.single_key = (key_count == CW'(1));
  assign sts.pass_end   = pass_end;
  assign sts.sort_done  = sort_done;
  assign sts.emit_last  = (i == last_idx);
  assign sts.out_free   = !result_valid || result_ready;
  assign sts.key_count  = key_count;

endmodule
